// ===== rtl/core/bco_pkg.sv =====
// Shared types, codes and beat layout for the box and circle overlap test.
package bco_pkg;

	localparam logic [1:0] SHAPE_BOX    = 2'd0;
	localparam logic [1:0] SHAPE_CIRCLE = 2'd1;

	localparam int unsigned S_TDATA_W = 160;
	localparam int unsigned M_TDATA_W = 8;

	// field offsets within s_tdata, lowest bit of each field
	localparam int unsigned OFS_SHAPE_A  = 0;
	localparam int unsigned OFS_POS_X_A  = 2;
	localparam int unsigned OFS_POS_Y_A  = 18;
	localparam int unsigned OFS_WIDTH_A  = 34;
	localparam int unsigned OFS_HEIGHT_A = 49;
	localparam int unsigned OFS_RADIUS_A = 64;
	localparam int unsigned OFS_SHAPE_B  = 79;
	localparam int unsigned OFS_POS_X_B  = 81;
	localparam int unsigned OFS_POS_Y_B  = 97;
	localparam int unsigned OFS_WIDTH_B  = 113;
	localparam int unsigned OFS_HEIGHT_B = 128;
	localparam int unsigned OFS_RADIUS_B = 143;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_BOX_BOX,
		KIND_CIRC_CIRC,
		KIND_CIRC_BOX
	} pair_kind_t;

	typedef struct packed {
		logic [1:0]         shape_a;
		logic signed [15:0] pos_x_a;
		logic signed [15:0] pos_y_a;
		logic [14:0]        width_a;
		logic [14:0]        height_a;
		logic [14:0]        radius_a;
		logic [1:0]         shape_b;
		logic signed [15:0] pos_x_b;
		logic signed [15:0] pos_y_b;
		logic [14:0]        width_b;
		logic [14:0]        height_b;
		logic [14:0]        radius_b;
	} pair_t;

	typedef struct packed {
		pair_kind_t  kind;
		logic        bb_hit;
		logic [15:0] dx_mag;
		logic [15:0] dy_mag;
		logic [15:0] r_mag;
	} prep_t;

	typedef struct packed {
		pair_kind_t  kind;
		logic        bb_hit;
		logic [31:0] dx_sq;
		logic [31:0] dy_sq;
		logic [31:0] r_sq;
	} sqr_t;

	// magnitude of an 18-bit signed difference known to lie within +-65535
	function automatic logic [15:0] abs_mag(input logic signed [17:0] v);
		logic signed [17:0] n;
		n = -v;
		return v[17] ? n[15:0] : v[15:0];
	endfunction

endpackage

// ===== rtl/core/box_circle_overlap_test.sv =====
// Box and circle pair overlap test, top level.
//
// One s_ beat carries a pair of shapes (box, circle or other) with Q12.4
// positions and Q11.4 sizes; one m_ beat returns the overlap bit for it.
// Every accepted pair gives exactly one result, in order.
//
// Four register stages: input register, classify/clamp/box compare,
// squaring, then the sum-and-compare into the output register. With no
// stall a pair passes through these registers in order before m_tvalid
// rises. The pipe takes one pair per cycle while the output does not stall,
// set by the single pass through the squaring stage.
//
// Each stage loads whenever it is empty or its successor moves, so bubbles
// close up and a held result at the output does not stop s_tready until all
// stages are full. With m_tready low and the pipe full, s_tready drops and
// all stages hold their data.
//
// Reset clears the valid bits of all stages; payload registers are not reset.
module box_circle_overlap_test
	import bco_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// shape_a, pos_x_a, pos_y_a, width_a, height_a, radius_a,
	// shape_b, pos_x_b, pos_y_b, width_b, height_b, radius_b, 2 zero bits
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// overlap, 7 zero bits
	output logic [M_TDATA_W-1:0] m_tdata
);

	logic  v_s1, v_s2, v_s3, v_q;
	logic  en_s1, en_s2, en_s3, en_q;
	pair_t pair_s1;
	prep_t prep_s2;
	sqr_t  sqr_s3;
	logic  overlap_q;

	logic [32:0] dist_sq;
	logic        hit;

	assign en_q  = !v_q || m_tready;
	assign en_s3 = !v_s3 || en_q;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_q)  v_q  <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			pair_s1.shape_a  <= s_tdata[OFS_SHAPE_A  +: 2];
			pair_s1.pos_x_a  <= s_tdata[OFS_POS_X_A  +: 16];
			pair_s1.pos_y_a  <= s_tdata[OFS_POS_Y_A  +: 16];
			pair_s1.width_a  <= s_tdata[OFS_WIDTH_A  +: 15];
			pair_s1.height_a <= s_tdata[OFS_HEIGHT_A +: 15];
			pair_s1.radius_a <= s_tdata[OFS_RADIUS_A +: 15];
			pair_s1.shape_b  <= s_tdata[OFS_SHAPE_B  +: 2];
			pair_s1.pos_x_b  <= s_tdata[OFS_POS_X_B  +: 16];
			pair_s1.pos_y_b  <= s_tdata[OFS_POS_Y_B  +: 16];
			pair_s1.width_b  <= s_tdata[OFS_WIDTH_B  +: 15];
			pair_s1.height_b <= s_tdata[OFS_HEIGHT_B +: 15];
			pair_s1.radius_b <= s_tdata[OFS_RADIUS_B +: 15];
		end
	end

	bco_prep u_prep (
		.clk     (clk),
		.en      (en_s2),
		.pair    (pair_s1),
		.prep_s2 (prep_s2)
	);

	bco_sqr u_sqr (
		.clk     (clk),
		.en      (en_s3),
		.prep_s2 (prep_s2),
		.sqr_s3  (sqr_s3)
	);

	// circle-circle is strict, circle-box touches count
	always_comb begin
		dist_sq = {1'b0, sqr_s3.dx_sq} + {1'b0, sqr_s3.dy_sq};
		case (sqr_s3.kind)
			KIND_BOX_BOX:   hit = sqr_s3.bb_hit;
			KIND_CIRC_CIRC: hit = dist_sq < {1'b0, sqr_s3.r_sq};
			KIND_CIRC_BOX:  hit = dist_sq <= {1'b0, sqr_s3.r_sq};
			default:        hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_q) begin
			overlap_q <= hit;
		end
	end

	assign m_tvalid = v_q;
	assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, overlap_q};

endmodule

// ===== rtl/core/bco_prep.sv =====
// Stage two: pair classification, box-box test, clamped distances and radius operand.
module bco_prep
	import bco_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  pair_t pair,
	output prep_t prep_s2
);

	pair_kind_t kind;
	logic       bb_hit;

	logic signed [17:0] l_a, r_a, t_a, b_a, l_b, r_b, t_b, b_b;

	logic               circ_is_a;
	logic signed [15:0] cx, cy, bx, by;
	logic [14:0]        cr, bw, bh;
	logic signed [17:0] lo_dx, hi_dx, lo_dy, hi_dy, cb_dx, cb_dy;
	logic signed [17:0] cc_dx, cc_dy;
	logic [15:0]        r_sum;
	prep_t              prep_d;

	always_comb begin
		if (pair.shape_a == SHAPE_BOX && pair.shape_b == SHAPE_BOX) begin
			kind = KIND_BOX_BOX;
		end else if (pair.shape_a == SHAPE_CIRCLE && pair.shape_b == SHAPE_CIRCLE) begin
			kind = KIND_CIRC_CIRC;
		end else if ((pair.shape_a == SHAPE_CIRCLE && pair.shape_b == SHAPE_BOX) ||
		             (pair.shape_a == SHAPE_BOX && pair.shape_b == SHAPE_CIRCLE)) begin
			kind = KIND_CIRC_BOX;
		end else begin
			kind = KIND_NONE;
		end
	end

	// box-box on doubled coordinates, centre position
	always_comb begin
		l_a = $signed({pair.pos_x_a[15], pair.pos_x_a, 1'b0}) - $signed({3'b000, pair.width_a});
		r_a = $signed({pair.pos_x_a[15], pair.pos_x_a, 1'b0}) + $signed({3'b000, pair.width_a});
		t_a = $signed({pair.pos_y_a[15], pair.pos_y_a, 1'b0}) - $signed({3'b000, pair.height_a});
		b_a = $signed({pair.pos_y_a[15], pair.pos_y_a, 1'b0}) + $signed({3'b000, pair.height_a});
		l_b = $signed({pair.pos_x_b[15], pair.pos_x_b, 1'b0}) - $signed({3'b000, pair.width_b});
		r_b = $signed({pair.pos_x_b[15], pair.pos_x_b, 1'b0}) + $signed({3'b000, pair.width_b});
		t_b = $signed({pair.pos_y_b[15], pair.pos_y_b, 1'b0}) - $signed({3'b000, pair.height_b});
		b_b = $signed({pair.pos_y_b[15], pair.pos_y_b, 1'b0}) + $signed({3'b000, pair.height_b});
		bb_hit = (l_a < r_b) && (r_a > l_b) && (t_a < b_b) && (b_a > t_b);
	end

	// circle-box: box position is its min corner
	always_comb begin
		circ_is_a = (pair.shape_a == SHAPE_CIRCLE);
		cx = circ_is_a ? pair.pos_x_a : pair.pos_x_b;
		cy = circ_is_a ? pair.pos_y_a : pair.pos_y_b;
		cr = circ_is_a ? pair.radius_a : pair.radius_b;
		bx = circ_is_a ? pair.pos_x_b : pair.pos_x_a;
		by = circ_is_a ? pair.pos_y_b : pair.pos_y_a;
		bw = circ_is_a ? pair.width_b : pair.width_a;
		bh = circ_is_a ? pair.height_b : pair.height_a;

		lo_dx = 18'(cx) - 18'(bx);
		hi_dx = lo_dx - $signed({3'b000, bw});
		lo_dy = 18'(cy) - 18'(by);
		hi_dy = lo_dy - $signed({3'b000, bh});

		if (lo_dx < 0) begin
			cb_dx = lo_dx;
		end else if (hi_dx > 0) begin
			cb_dx = hi_dx;
		end else begin
			cb_dx = '0;
		end
		if (lo_dy < 0) begin
			cb_dy = lo_dy;
		end else if (hi_dy > 0) begin
			cb_dy = hi_dy;
		end else begin
			cb_dy = '0;
		end

		cc_dx = 18'(pair.pos_x_a) - 18'(pair.pos_x_b);
		cc_dy = 18'(pair.pos_y_a) - 18'(pair.pos_y_b);
		r_sum = {1'b0, pair.radius_a} + {1'b0, pair.radius_b};
	end

	always_comb begin
		prep_d.kind   = kind;
		prep_d.bb_hit = bb_hit;
		if (kind == KIND_CIRC_CIRC) begin
			prep_d.dx_mag = abs_mag(cc_dx);
			prep_d.dy_mag = abs_mag(cc_dy);
			prep_d.r_mag  = r_sum;
		end else begin
			prep_d.dx_mag = abs_mag(cb_dx);
			prep_d.dy_mag = abs_mag(cb_dy);
			prep_d.r_mag  = {1'b0, cr};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prep_s2 <= prep_d;
		end
	end

endmodule

// ===== rtl/core/bco_sqr.sv =====
// Stage three: squares of the distance components and of the radius term.
module bco_sqr
	import bco_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  prep_t prep_s2,
	output sqr_t  sqr_s3
);

	always_ff @(posedge clk) begin
		if (en) begin
			sqr_s3.kind   <= prep_s2.kind;
			sqr_s3.bb_hit <= prep_s2.bb_hit;
			sqr_s3.dx_sq  <= prep_s2.dx_mag * prep_s2.dx_mag;
			sqr_s3.dy_sq  <= prep_s2.dy_mag * prep_s2.dy_mag;
			sqr_s3.r_sq   <= prep_s2.r_mag * prep_s2.r_mag;
		end
	end

endmodule

// ===== rtl/core/bco_checker.sv =====
// Port-level checks on the overlap test, bound to its top level.
module bco_checker
	import bco_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TDATA_W-1:0] s_tdata,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// a stalled input beat holds
	a_s_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("stalled input beat changed");

	// a stalled result beat holds
	a_m_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result beat changed");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_TDATA_W-1:1] == '0)
		else $error("result pad bits not zero");

	// an output that is empty or draining never blocks the input side
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled with output free");

	// with no output stall an accepted beat shows up at the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
		else $error("result missing after four free cycles");

endmodule

bind box_circle_overlap_test bco_checker u_bco_checker (.*);
